>>> hdl/sync_length_sum_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// sync_length_sum_frame_parser_macros
// Assertion macros shared by the frame parser modules. They expect clk and
// rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define SLSFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/slsfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfp_pkg
// Constants, state encoding and controller/datapath interface types of the
// length-prefixed frame parser.
// ----------------------------------------------------------------------------
package slsfp_pkg;

  localparam int MAX_LEN = 32;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int SEQ_W   = 8;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAB;

  typedef enum logic [2:0] {
    ST_HUNT_FIRST,
    ST_HUNT_SECOND,
    ST_CHAN,
    ST_LEN,
    ST_BODY,
    ST_READ,
    ST_LOAD
  } st_t;

  typedef struct packed {
    logic bump_hdr;
    logic load_len;
    logic store_byte;
    logic start_emit;
    logic rd_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic len_ok;
    logic body_more;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/slsfp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module slsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/slsfp_dp.sv
`timescale 1ns / 1ps
`include "sync_length_sum_frame_parser_macros.svh"
// ----------------------------------------------------------------------------
// slsfp_dp
// Parser datapath: frame store, length, fill count, running checksum,
// header counter, playout index and the result register.
// ----------------------------------------------------------------------------
module slsfp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [slsfp_pkg::BYTE_W-1:0]  rx_byte,
  input  slsfp_pkg::dp_cmd_t            cmd,
  output slsfp_pkg::dp_sts_t            sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slsfp_pkg::SEQ_W-1:0]   out_frame_seq,
  output logic [slsfp_pkg::BYTE_W-1:0]  out_byte_value,
  output logic [slsfp_pkg::POS_W-1:0]   out_byte_pos,
  output logic                          out_last
);
  import slsfp_pkg::*;

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [SEQ_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [CNT_W-1:0]  emit_idx_r, emit_idx_nxt;

  logic              out_valid_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_last_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  // the length byte goes to entry zero, body bytes follow it
  assign ram_we    = cmd.load_len | cmd.store_byte;
  assign ram_waddr = cmd.load_len ? '0 : fill_r[ADDR_W-1:0];

  slsfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (emit_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.is_first  = (rx_byte == HDR_FIRST);
    sts.is_second = (rx_byte == HDR_SECOND);
    sts.len_ok    = (rx_byte != '0) && (rx_byte <= BYTE_W'(MAX_LEN));
    sts.body_more = (fill_r < len_r);
    sts.sum_match = (rx_byte == sum_r);
    sts.emit_last = ((emit_idx_r + CNT_W'(1)) == len_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    emit_idx_nxt = emit_idx_r;
    if (cmd.bump_hdr) begin
      hdr_cnt_nxt = hdr_cnt_r + SEQ_W'(1);
      fill_nxt    = '0;
    end
    if (cmd.load_len) begin
      len_nxt  = CNT_W'(rx_byte);
      fill_nxt = CNT_W'(1);
      sum_nxt  = rx_byte;
    end
    if (cmd.store_byte) begin
      fill_nxt = fill_r + CNT_W'(1);
      sum_nxt  = sum_r + rx_byte;
    end
    if (cmd.start_emit) begin
      emit_idx_nxt = '0;
    end
    if (cmd.out_load) begin
      emit_idx_nxt = emit_idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      hdr_cnt_r   <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded from the store's registered read port
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_seq_r  <= hdr_cnt_r - SEQ_W'(1);
      out_byte_r <= ram_rdata;
      out_pos_r  <= POS_W'(emit_idx_r);
      out_last_r <= sts.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_seq  = out_seq_r;
  assign out_byte_value = out_byte_r;
  assign out_byte_pos   = out_pos_r;
  assign out_last       = out_last_r;

  `SLSFP_ASSERT_NOW(a_load_when_free, cmd.out_load, (!out_valid_r || out_ready), "result overwritten before transfer")
  `SLSFP_ASSERT_NOW(a_store_in_range, cmd.store_byte, (fill_r < len_r), "body byte stored past frame length")
  `SLSFP_ASSERT_NOW(a_emit_nonempty, cmd.start_emit, (len_r != '0), "playout started with empty frame")

endmodule

>>> hdl/slsfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfp_ctrl
// Parser controller: header hunt, length check, body capture, checksum
// decision and frame playout sequencing.
// ----------------------------------------------------------------------------
module slsfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slsfp_pkg::dp_sts_t sts,
  output slsfp_pkg::dp_cmd_t cmd
);
  import slsfp_pkg::*;

  st_t  state_r, state_nxt;
  logic in_xfer;

  always_comb begin
    unique case (state_r)
      ST_READ, ST_LOAD: in_ready = 1'b0;
      default:          in_ready = 1'b1;
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT_FIRST: begin
        if (in_xfer && sts.is_first) state_nxt = ST_HUNT_SECOND;
      end
      ST_HUNT_SECOND: begin
        if (in_xfer) state_nxt = sts.is_second ? ST_CHAN : ST_HUNT_FIRST;
      end
      ST_CHAN: begin
        if (in_xfer) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (in_xfer) state_nxt = sts.len_ok ? ST_BODY : ST_HUNT_FIRST;
      end
      ST_BODY: begin
        if (in_xfer && !sts.body_more) begin
          state_nxt = sts.sum_match ? ST_READ : ST_HUNT_FIRST;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (sts.out_free) state_nxt = sts.emit_last ? ST_HUNT_FIRST : ST_READ;
      end
      default: state_nxt = ST_HUNT_FIRST;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CHAN: cmd.bump_hdr = in_xfer;
      ST_LEN:  cmd.load_len = in_xfer && sts.len_ok;
      ST_BODY: begin
        cmd.store_byte = in_xfer && sts.body_more;
        cmd.start_emit = in_xfer && !sts.body_more && sts.sum_match;
      end
      ST_READ: cmd.rd_issue = 1'b1;
      ST_LOAD: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT_FIRST;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/sync_length_sum_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_frame_parser
// Length-prefixed serial frame parser with an 8-bit additive checksum.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_rx_byte
//   out_     out  out_valid/out_ready  out_frame_seq, out_byte_value,
//                                      out_byte_pos, out_last
//
// One received byte is taken per cycle while the parser hunts or captures.
// After a good checksum byte the input stalls while the stored frame plays
// out; each byte is a store read, then a result register load, as the frame
// store has a registered read port, and out_ready stalls hold the load back.
// Synchronous active-low reset clears the control state; the frame store is
// not cleared, since only bytes written by the current frame are read back.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [slsfp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slsfp_pkg::SEQ_W-1:0]   out_frame_seq,
  output logic [slsfp_pkg::BYTE_W-1:0]  out_byte_value,
  output logic [slsfp_pkg::POS_W-1:0]   out_byte_pos,
  output logic                          out_last
);
  import slsfp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  slsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slsfp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_seq  (out_frame_seq),
    .out_byte_value (out_byte_value),
    .out_byte_pos   (out_byte_pos),
    .out_last       (out_last)
  );

endmodule

>>> tb/tb_sync_length_sum_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_sum_frame_parser
// Feeds a byte stream of good frames, broken headers, bad lengths, bad
// checksums and noise into the frame parser. A behavioral parser inside the
// bench predicts every emitted frame byte, and each result transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sync_length_sum_frame_parser;
  import slsfp_pkg::*;

  localparam int TAIL_LEN = 40;

  typedef struct {
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_byte_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [SEQ_W-1:0]  out_frame_seq;
  logic [BYTE_W-1:0] out_byte_value;
  logic [POS_W-1:0]  out_byte_pos;
  logic              out_last;

  // pending rx bytes and predicted frame bytes
  logic [BYTE_W-1:0] rx_feed_q[$];
  frame_byte_t       frame_bytes_q[$];

  // behavioral parser state
  st_t               parse_st;
  logic [BYTE_W-1:0] frame_buf[MAX_LEN];
  int                fill_cnt;
  int                frame_len;
  logic [BYTE_W-1:0] byte_sum;
  logic [SEQ_W-1:0]  hdr_count;

  int   err_cnt;
  int   in_gap;
  int   out_gap;
  logic in_taken;

  sync_length_sum_frame_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_seq  (out_frame_seq),
    .out_byte_value (out_byte_value),
    .out_byte_pos   (out_byte_pos),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void parse_rx_byte(logic [BYTE_W-1:0] b);
    frame_byte_t fb;
    case (parse_st)
      ST_HUNT_SECOND: parse_st = (b == HDR_SECOND) ? ST_CHAN : ST_HUNT_FIRST;
      ST_CHAN: begin
        hdr_count++;
        fill_cnt = 0;
        parse_st = ST_LEN;
      end
      ST_LEN: begin
        if (b == 0 || b > MAX_LEN) begin
          parse_st = ST_HUNT_FIRST;
        end else begin
          frame_len    = b;
          frame_buf[0] = b;
          fill_cnt     = 1;
          byte_sum     = b;
          parse_st     = ST_BODY;
        end
      end
      ST_BODY: begin
        if (fill_cnt < frame_len) begin
          frame_buf[fill_cnt] = b;
          fill_cnt++;
          byte_sum += b;
        end else begin
          // checksum byte: emit the frame only on a match
          if (b == byte_sum) begin
            for (int k = 0; k < frame_len; k++) begin
              fb.seq   = hdr_count - 8'd1;
              fb.value = frame_buf[k];
              fb.pos   = POS_W'(k);
              fb.last  = (k + 1 == frame_len);
              frame_bytes_q.push_back(fb);
            end
          end
          parse_st = ST_HUNT_FIRST;
        end
      end
      default: parse_st = (b == HDR_FIRST) ? ST_HUNT_SECOND : ST_HUNT_FIRST;
    endcase
  endfunction

  task automatic push_header(logic [BYTE_W-1:0] chan);
    rx_feed_q.push_back(HDR_FIRST);
    rx_feed_q.push_back(HDR_SECOND);
    rx_feed_q.push_back(chan);
  endtask

  task automatic push_frame(logic [BYTE_W-1:0] chan, int len, bit bad_sum);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    push_header(chan);
    rx_feed_q.push_back(BYTE_W'(len));
    sum = BYTE_W'(len);
    for (int i = 1; i < len; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      rx_feed_q.push_back(b);
      sum += b;
    end
    if (bad_sum) sum ^= BYTE_W'($urandom_range(1, 255));
    rx_feed_q.push_back(sum);
  endtask

  // stimulus, then the end of the run
  initial begin
    int pick;
    int len;
    logic [BYTE_W-1:0] b;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_ready  = 1'b0;
    in_taken   = 1'b0;
    in_gap     = 0;
    out_gap    = 0;
    err_cnt    = 0;
    parse_st   = ST_HUNT_FIRST;
    fill_cnt   = 0;
    frame_len  = 0;
    byte_sum   = '0;
    hdr_count  = '0;

    // repeated first header byte does not restart the header
    rx_feed_q.push_back(HDR_FIRST);
    rx_feed_q.push_back(HDR_FIRST);
    rx_feed_q.push_back(HDR_SECOND);
    rx_feed_q.push_back(8'h01);
    rx_feed_q.push_back(8'h01);
    // shortest frame
    push_frame(8'h00, 1, 1'b0);
    // zero length and length just above the maximum
    push_header(8'h80);
    rx_feed_q.push_back(8'h00);
    push_header(8'h7F);
    rx_feed_q.push_back(BYTE_W'(MAX_LEN + 1));
    // checksum mismatch
    push_header(8'hFF);
    rx_feed_q.push_back(8'h02);
    rx_feed_q.push_back(8'hFF);
    rx_feed_q.push_back(8'h00);
    // checksum that wraps past 255
    push_header(8'h55);
    rx_feed_q.push_back(8'h02);
    rx_feed_q.push_back(8'hFF);
    rx_feed_q.push_back(8'h01);

    // random part: mostly good frames, some broken ones and noise
    for (int n = 0; n < 78; n += len) begin
      pick = $urandom_range(0, 19);
      len  = 1;
      if (pick < 14) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) len = $urandom_range(1, 6);
        else if (pick < 19) len = $urandom_range(7, MAX_LEN - 1);
        else len = MAX_LEN;
        push_frame(BYTE_W'($urandom_range(0, 255)), len, 1'b0);
        len += 4;
      end else if (pick < 16) begin
        len = $urandom_range(1, 6);
        push_frame(BYTE_W'($urandom_range(0, 255)), len, 1'b1);
        len += 4;
      end else if (pick < 18) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) rx_feed_q.push_back(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 19) begin
        push_header(BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) rx_feed_q.push_back(8'h00);
        else rx_feed_q.push_back(BYTE_W'($urandom_range(MAX_LEN + 1, 255)));
        len = 4;
      end else begin
        rx_feed_q.push_back(HDR_FIRST);
        do b = BYTE_W'($urandom_range(0, 255)); while (b == HDR_SECOND);
        rx_feed_q.push_back(b);
        len = 2;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_feed_q.size() > 0 || in_valid) @(posedge clk);
    while (frame_bytes_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (frame_bytes_q.size() > 0)
      report_mismatch($sformatf("%0d frame bytes never emitted", frame_bytes_q.size()));

    if (err_cnt == 0) begin
      $display("sync_length_sum_frame_parser test passed");
    end else begin
      $display("sync_length_sum_frame_parser test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sync_length_sum_frame_parser test failed");
    $finish;
  end

  // drive both channels at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap == 0 && rx_feed_q.size() > TAIL_LEN && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 3);
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (rx_feed_q.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;

      if (out_gap == 0 && rx_feed_q.size() > TAIL_LEN && $urandom_range(0, 4) == 0)
        out_gap = $urandom_range(1, 3);
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // sample transfers at the rising edge
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_rx_byte(in_rx_byte);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, byte_value %0h",
                                    out_byte_value));
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_frame_seq !== want.seq)
            report_mismatch($sformatf("frame_seq got %0d want %0d", out_frame_seq, want.seq));
          if (out_byte_value !== want.value)
            report_mismatch($sformatf("byte_value got %0h want %0h", out_byte_value,
                                      want.value));
          if (out_byte_pos !== want.pos)
            report_mismatch($sformatf("byte_pos got %0d want %0d", out_byte_pos, want.pos));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        end
      end
    end
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/slsfp_pkg.sv
hdl/slsfp_ram.sv
hdl/slsfp_dp.sv
hdl/slsfp_ctrl.sv
hdl/sync_length_sum_frame_parser.sv
tb/tb_sync_length_sum_frame_parser.sv
